>>> rtl/mbc_pkg.sv
// shared types, s-box table and key schedule helpers for the magma block cipher
package mbc_pkg;

   localparam int unsigned ROUNDS     = 32;
   localparam int unsigned ROUND_BITS = $clog2(ROUNDS);
   localparam int unsigned HALF_BITS  = 32;
   localparam int unsigned KEY_WORDS  = 8;
   localparam int unsigned ROT_LEFT   = 11;

   typedef logic [KEY_WORDS-1:0][HALF_BITS-1:0] key_words_type;

   // block state carried from cell to cell
   typedef struct packed {
      logic                 decrypt;
      logic [HALF_BITS-1:0] a1;
      logic [HALF_BITS-1:0] a0;
   } round_data_type;

   localparam logic [3:0] SBOX [0:7][0:15] = '{
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
      '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
        4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
      '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
        4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
      '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
        4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
      '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
        4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
      '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
        4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
      '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
        4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
   };

   // key word used at encryption round idx: forward three times, then reversed
   function automatic logic [2:0] key_select(input logic [ROUND_BITS-1:0] idx);
      logic [2:0] sel;
      sel = idx[2:0];
      if (idx[ROUND_BITS-1:3] == 2'b11) begin
         sel = ~idx[2:0];
      end
      return sel;
   endfunction

   // round function: add key, s-box substitution, rotate left by 11
   function automatic logic [HALF_BITS-1:0] round_g(input logic [HALF_BITS-1:0] half,
                                                    input logic [HALF_BITS-1:0] k);
      logic [HALF_BITS-1:0] sum;
      logic [HALF_BITS-1:0] t;
      sum = half + k;
      for (int i = 0; i < 8; i++) begin
         t[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
      end
      return {t[HALF_BITS-ROT_LEFT-1:0], t[HALF_BITS-1:HALF_BITS-ROT_LEFT]};
   endfunction

endpackage

>>> rtl/mbc_round_cell.sv
// one feistel round cell with its own valid/ready stage
module mbc_round_cell
   import mbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ROUND_BITS-1:0] stage_num,
   input  key_words_type         key_words,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  round_data_type        in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output round_data_type        out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   round_data_type        data_ff;
   round_data_type        data_in;
   logic [ROUND_BITS-1:0] sched_idx;
   logic [HALF_BITS-1:0]  stage_key;

   // decryption walks the schedule backwards: 31 - r
   assign sched_idx = in_data.decrypt ? ~stage_num : stage_num;
   // word n of the key sits in slot 7 - n
   assign stage_key = key_words[~key_select(sched_idx)];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in        = in_valid;
         data_in.decrypt = in_data.decrypt;
         data_in.a1      = in_data.a0;
         data_in.a0      = in_data.a1 ^ round_g(in_data.a0, stage_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> rtl/magma_block_cipher.sv
// magma 64-bit block cipher top level: key registers and 32-cell round chain
// a request passes through the register of every cell in order before rsp_valid rises
// throughput: one request per cycle; each cell stalls only while its own result waits
// the last cell's register is the output register, so cells upstream keep filling
// reset: synchronous active-high reset empties every cell and clears the key to zero
module magma_block_cipher
   import mbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [63:0] req_block_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_block_out
);

   localparam logic [1:0] CSR_KEY_A = 2'd0;
   localparam logic [1:0] CSR_KEY_B = 2'd1;
   localparam logic [1:0] CSR_KEY_C = 2'd2;
   localparam logic [1:0] CSR_KEY_D = 2'd3;

   logic [63:0]   key_a_ff;
   logic [63:0]   key_b_ff;
   logic [63:0]   key_c_ff;
   logic [63:0]   key_d_ff;
   key_words_type key_words;

   // handshake and data wiring between neighboring cells; index 0 is the chain input
   logic           link_valid [0:ROUNDS];
   logic           link_ready [0:ROUNDS];
   round_data_type link_data  [0:ROUNDS];

   // key registers; the user must write them only while the chain is idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_ff <= '0;
         key_b_ff <= '0;
         key_c_ff <= '0;
         key_d_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_A: key_a_ff <= csr_wdata;
            CSR_KEY_B: key_b_ff <= csr_wdata;
            CSR_KEY_C: key_c_ff <= csr_wdata;
            CSR_KEY_D: key_d_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // word K1 sits in the top slot, K8 in slot 0
   assign key_words = {key_a_ff, key_b_ff, key_c_ff, key_d_ff};

   // request enters the first cell; upper half of the block is the left half a1
   assign link_valid[0]      = req_valid;
   assign req_ready          = link_ready[0];
   assign link_data[0].decrypt = req_opcode;
   assign link_data[0].a1    = req_block_in[63:32];
   assign link_data[0].a0    = req_block_in[31:0];

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      mbc_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_num (ROUND_BITS'(r)),
         .key_words (key_words),
         .in_valid  (link_valid[r]),
         .in_ready  (link_ready[r]),
         .in_data   (link_data[r]),
         .out_valid (link_valid[r+1]),
         .out_ready (link_ready[r+1]),
         .out_data  (link_data[r+1])
      );
   end

   // final swap: a0 goes out in the upper half
   assign rsp_valid           = link_valid[ROUNDS];
   assign link_ready[ROUNDS]  = rsp_ready;
   assign rsp_block_out       = {link_data[ROUNDS].a0, link_data[ROUNDS].a1};

endmodule
